>>> design/bracket_nesting_depth_macros.svh
// Assertion helpers for the bracket nesting depth block.
`ifndef BRACKET_NESTING_DEPTH_MACROS_SVH
`define BRACKET_NESTING_DEPTH_MACROS_SVH

// Same-cycle implication, off during reset.
`define BND_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define BND_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, always checked.
`define BND_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/bnd_pkg.sv
package bnd_pkg;

   localparam int START_W = 32;
   localparam int LEN_W   = 32;
   localparam int END_W   = 33;
   localparam int DEPTH_W = 6;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = 6'd63;

   // classified word passed from front to back
   typedef struct packed {
      logic [START_W-1:0] bracket_start;
      logic [END_W-1:0]   end_pos;
      logic               span_valid;
      logic [DEPTH_W-1:0] previous_depth;
      logic               previous_invalid;
      logic               last_of_pass;
   } item_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] nesting_depth;
      logic               depth_invalid;
      logic               depth_changed;
      logic               stack_overflow;
   } result_type;

endpackage

>>> design/bnd_if.sv
interface bnd_req_if;
   logic                         valid;
   logic                         ready;
   logic [bnd_pkg::START_W-1:0]  bracket_start;
   logic [bnd_pkg::LEN_W-1:0]    span_length;
   logic                         span_valid;
   logic [bnd_pkg::DEPTH_W-1:0]  previous_depth;
   logic                         previous_invalid;
   logic                         last_of_pass;

   modport source (output valid, bracket_start, span_length, span_valid, previous_depth,
                   previous_invalid, last_of_pass, input ready);
   modport sink (input valid, bracket_start, span_length, span_valid, previous_depth,
                 previous_invalid, last_of_pass, output ready);
endinterface

interface bnd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bnd_pkg::DEPTH_W-1:0]  nesting_depth;
   logic                         depth_invalid;
   logic                         depth_changed;
   logic                         stack_overflow;

   modport source (output valid, nesting_depth, depth_invalid, depth_changed,
                   stack_overflow, input ready);
   modport sink (input valid, nesting_depth, depth_invalid, depth_changed,
                 stack_overflow, output ready);
endinterface

>>> design/bnd_ram.sv
module bnd_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/bnd_front.sv
module bnd_front (
   input  logic              clock,
   input  logic              reset,
   bnd_req_if.sink           req_chan,
   output logic              out_valid,
   output bnd_pkg::item_type out_item,
   input  logic              out_ready
);
   logic              hold_valid_ff, hold_valid_in;
   bnd_pkg::item_type hold_ff, hold_in;
   logic              take;

   assign req_chan.ready = !hold_valid_ff || out_ready;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in = hold_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         hold_in.bracket_start = req_chan.bracket_start;
         // end position, 33 bits so it never wraps
         hold_in.end_pos = {1'b0, req_chan.bracket_start} + {1'b0, req_chan.span_length};
         hold_in.span_valid = req_chan.span_valid;
         hold_in.previous_depth = req_chan.previous_depth;
         hold_in.previous_invalid = req_chan.previous_invalid;
         hold_in.last_of_pass = req_chan.last_of_pass;
      end else if (out_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   assign out_valid = hold_valid_ff;
   assign out_item = hold_ff;
endmodule

>>> design/bnd_queue.sv
module bnd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  bnd_pkg::item_type in_item,
   output logic              in_ready,
   output logic              out_valid,
   output bnd_pkg::item_type out_item,
   input  logic              out_ready
);
   localparam int SLOTS = 2;

   bnd_pkg::item_type slot_ff [SLOTS];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push, pop;

   assign in_ready = fill_ff != 2'(SLOTS);
   assign out_valid = fill_ff != 2'd0;
   assign out_item = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

>>> design/bnd_back.sv
module bnd_back #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  bnd_pkg::item_type   in_item,
   output logic                in_ready,
   output logic                rsp_valid,
   output bnd_pkg::result_type rsp_data,
   input  logic                rsp_ready
);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(STACK_DEPTH);
   localparam int XW = (CW > bnd_pkg::DEPTH_W) ? CW : bnd_pkg::DEPTH_W;

   localparam logic ST_EXEC = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   logic                  state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [bnd_pkg::END_W-1:0] top_ff, top_in;
   logic                  out_valid_ff, out_valid_in;
   bnd_pkg::result_type   out_ff, out_in;

   logic                  out_free, full, need_pop;
   logic [CW-1:0]         cnt_m1, cnt_m2, raw_depth;
   logic [XW-1:0]         raw_x;
   logic [bnd_pkg::DEPTH_W-1:0] depth;
   logic                  wr_en, rd_en;
   logic [bnd_pkg::END_W-1:0] rd_data;

   assign out_free = !out_valid_ff || rsp_ready;
   assign full = count_ff == CW'(STACK_DEPTH);
   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);
   assign need_pop = (count_ff != '0) && (top_ff < {1'b0, in_item.bracket_start});

   // depth after the push: count - 1 on a dropped push, else old count
   assign raw_depth = full ? cnt_m1 : count_ff;
   assign raw_x = XW'(raw_depth);
   assign depth = (raw_x > XW'(bnd_pkg::DEPTH_MAX)) ? bnd_pkg::DEPTH_MAX
                                                   : raw_x[bnd_pkg::DEPTH_W-1:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      top_in = top_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in = out_ff;
      in_ready = 1'b0;
      wr_en = 1'b0;
      rd_en = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            if (in_valid) begin
               if (!in_item.span_valid) begin
                  if (out_free) begin
                     in_ready = 1'b1;
                     out_valid_in = 1'b1;
                     out_in = '{nesting_depth: '0, depth_invalid: 1'b1,
                                depth_changed: 1'b0, stack_overflow: 1'b0};
                     if (in_item.last_of_pass) begin
                        count_in = '0;
                     end
                  end
               end else if (need_pop) begin
                  count_in = cnt_m1;
                  if (count_ff > CW'(1)) begin
                     rd_en = 1'b1;
                     state_in = ST_LOAD;
                  end
               end else if (out_free) begin
                  in_ready = 1'b1;
                  out_valid_in = 1'b1;
                  out_in.nesting_depth = depth;
                  out_in.depth_invalid = 1'b0;
                  out_in.depth_changed = in_item.previous_invalid
                                         || (depth != in_item.previous_depth);
                  out_in.stack_overflow = full;
                  if (!full) begin
                     // old top drops into the RAM, new end becomes the top
                     wr_en = count_ff != '0;
                     top_in = in_item.end_pos;
                     count_in = count_ff + CW'(1);
                  end
                  if (in_item.last_of_pass) begin
                     count_in = '0;
                  end
               end
            end
         end
         ST_LOAD: begin
            top_in = rd_data;
            state_in = ST_EXEC;
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   bnd_ram #(
      .WIDTH (bnd_pkg::END_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_m1[IW-1:0]),
      .wr_data (top_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_m2[IW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EXEC;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
      top_ff <= top_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
endmodule

>>> design/bracket_nesting_depth.sv
// An accepted req word is registered in the front, passes the queue and is registered again
// in the back output register, after any pops it causes. The back end takes 1 word per cycle
// with no pops and no rsp stall; a pop decrements and reads the RAM, then loads the registered
// read data as new top, or only decrements if it empties the stack. Each entry pops at most once.
// Reset (synchronous, active high) empties the stack count, queue and output register;
// stack RAM contents are not cleared, since only entries below the count are ever read.
module bracket_nesting_depth #(
   parameter int STACK_DEPTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   bnd_req_if.sink  req_chan,
   bnd_rsp_if.source rsp_chan
);
   // front: registers the req word and forms the 33-bit end position
   logic              fr_valid, fr_ready;
   bnd_pkg::item_type fr_item;

   // queue head seen by the back end
   logic              q_valid, q_ready;
   bnd_pkg::item_type q_item;

   bnd_pkg::result_type result;

   bnd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (fr_valid),
      .out_item  (fr_item),
      .out_ready (fr_ready)
   );

   // two-word decoupling queue: the front keeps taking words while the back pops the stack
   bnd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_item   (fr_item),
      .in_ready  (fr_ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_ready (q_ready)
   );

   // back: stack of end positions, cached top register plus RAM for the rest,
   // result held in an output register that frees up as rsp takes it
   bnd_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .in_ready  (q_ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (result),
      .rsp_ready (rsp_chan.ready)
   );

   assign rsp_chan.nesting_depth = result.nesting_depth;
   assign rsp_chan.depth_invalid = result.depth_invalid;
   assign rsp_chan.depth_changed = result.depth_changed;
   assign rsp_chan.stack_overflow = result.stack_overflow;
endmodule

>>> design/bnd_checker.sv
`include "bracket_nesting_depth_macros.svh"

module bnd_checker #(
   parameter int STACK_DEPTH = 64
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bnd_pkg::DEPTH_W-1:0] rsp_depth,
   input logic                        rsp_invalid,
   input logic                        rsp_changed,
   input logic                        rsp_overflow
);
   localparam int OVF_DEPTH = (STACK_DEPTH - 1 > 63) ? 63 : STACK_DEPTH - 1;

   `BND_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_depth) && $stable(rsp_invalid) && $stable(rsp_changed) && $stable(rsp_overflow), "rsp word changed while stalled")
   `BND_ASSERT_IMP(a_invalid_clean, clock, reset, rsp_valid && rsp_invalid, rsp_depth == '0 && !rsp_changed && !rsp_overflow, "invalid bracket result not clean")
   `BND_ASSERT_IMP(a_overflow_depth, clock, reset, rsp_valid && rsp_overflow, !rsp_invalid && rsp_depth == bnd_pkg::DEPTH_W'(OVF_DEPTH), "overflow without full-stack depth")
   `BND_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "rsp valid right after reset")
endmodule

bind bracket_nesting_depth bnd_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_bnd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_depth    (rsp_chan.nesting_depth),
   .rsp_invalid  (rsp_chan.depth_invalid),
   .rsp_changed  (rsp_chan.depth_changed),
   .rsp_overflow (rsp_chan.stack_overflow)
);

>>> verif/bracket_nesting_depth_tb.sv
module bracket_nesting_depth_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_ENTRIES = 64;

   // Two copies of the open-span stack: one advanced while the stimulus is
   // built (so previous_depth can echo the real depth), one advanced on
   // every word the block actually accepts.
   typedef enum int {CHECK_VIEW = 0, GEN_VIEW = 1} stack_view_type;

   // One request word plus a flag that makes the sender drain first.
   typedef struct packed {
      logic [bnd_pkg::START_W-1:0] bracket_start;
      logic [bnd_pkg::LEN_W-1:0]   span_length;
      logic                        span_valid;
      logic [bnd_pkg::DEPTH_W-1:0] previous_depth;
      logic                        previous_invalid;
      logic                        last_of_pass;
      logic                        pause_before;
   } bracket_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bnd_req_if req_bus ();
   bnd_rsp_if rsp_bus ();

   bracket_nesting_depth #(.STACK_DEPTH(STACK_ENTRIES)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Driven signals: local regs with known start values, tied to the bus
   // ------------------------------------------------------------------
   bracket_word_type cur_word = '0;
   logic             req_vld  = 1'b0;
   logic             rsp_rdy  = 1'b0;

   assign req_bus.valid            = req_vld;
   assign req_bus.bracket_start    = cur_word.bracket_start;
   assign req_bus.span_length      = cur_word.span_length;
   assign req_bus.span_valid       = cur_word.span_valid;
   assign req_bus.previous_depth   = cur_word.previous_depth;
   assign req_bus.previous_invalid = cur_word.previous_invalid;
   assign req_bus.last_of_pass     = cur_word.last_of_pass;
   assign rsp_bus.ready            = rsp_rdy;

   bracket_word_type     pending_words [$];
   bnd_pkg::result_type  expected_results [$];
   int                   accepted_count = 0;
   int                   mismatches     = 0;
   bit                   req_taken      = 1'b0;

   // Neither side idles at random while this many words go through; drain pauses still apply.
   wire calm_stretch = (accepted_count >= 700) && (accepted_count < 900);

   // ------------------------------------------------------------------
   // Depth predictor: stack of span end positions, 33 bits, no wrap
   // ------------------------------------------------------------------
   logic [bnd_pkg::END_W-1:0] open_ends [2][STACK_ENTRIES];
   int                        open_count [2] = '{0, 0};

   function automatic bnd_pkg::result_type compute_nesting(input stack_view_type view,
                                                           input bracket_word_type w);
      bnd_pkg::result_type       r;
      logic [bnd_pkg::END_W-1:0] start_ext;
      logic [bnd_pkg::END_W-1:0] end_pos;
      int                        depth;
      r = '0;
      if (!w.span_valid) begin
         // invalid bracket: stack untouched, depth zero
         r.depth_invalid = 1'b1;
      end else begin
         start_ext = {1'b0, w.bracket_start};
         end_pos   = start_ext + {1'b0, w.span_length};
         // only when the start lies past the top do we close spans
         if (open_count[view] > 0 && start_ext > open_ends[view][open_count[view]-1]) begin
            while (open_count[view] > 0 && open_ends[view][open_count[view]-1] < start_ext)
               open_count[view]--;
         end
         if (open_count[view] < STACK_ENTRIES) begin
            open_ends[view][open_count[view]] = end_pos;
            open_count[view]++;
         end else begin
            r.stack_overflow = 1'b1;   // push dropped, depth from full stack
         end
         depth = (open_count[view] > 0) ? open_count[view] - 1 : 0;
         if (depth > int'(bnd_pkg::DEPTH_MAX))
            depth = int'(bnd_pkg::DEPTH_MAX);
         r.nesting_depth = depth[bnd_pkg::DEPTH_W-1:0];
         r.depth_changed = w.previous_invalid || (r.nesting_depth != w.previous_depth);
      end
      // end of pass empties the stack after the result, valid or not
      if (w.last_of_pass)
         open_count[view] = 0;
      return r;
   endfunction

   // Queue one word. With echo set, previous_depth is the depth this word will
   // really get, so depth_changed mostly stays low on such words.
   task automatic add_word(input logic [bnd_pkg::START_W-1:0] start,
                           input logic [bnd_pkg::LEN_W-1:0] len,
                           input bit valid, input bit echo,
                           input logic [bnd_pkg::DEPTH_W-1:0] prev,
                           input bit prev_inv, input bit last);
      bracket_word_type    w;
      bnd_pkg::result_type r;
      w.bracket_start    = start;
      w.span_length      = len;
      w.span_valid       = valid;
      w.previous_depth   = prev;
      w.previous_invalid = prev_inv;
      w.last_of_pass     = last;
      // one forced drain mid-run, plus a rare random one
      w.pause_before     = (pending_words.size() == 500) || ($urandom_range(0, 99) == 0);
      r = compute_nesting(GEN_VIEW, w);
      if (echo)
         w.previous_depth = r.nesting_depth;
      pending_words.push_back(w);
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: new word at the falling edge once the last one is taken
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      bit offer;
      offer = 1'b0;
      if (!reset) begin
         if (req_vld && !req_taken) begin
            offer = 1'b1;   // hold the word until it is accepted
         end else if (pending_words.size() != 0 &&
                      !(pending_words[0].pause_before && expected_results.size() != 0) &&
                      (calm_stretch || $urandom_range(0, 99) >= 19)) begin
            cur_word = pending_words.pop_front();
            offer    = 1'b1;
         end
      end
      req_vld <= offer;
   end

   // ------------------------------------------------------------------
   // Receiver ready: random idling, and one long hold-off that lets the
   // block fill up and push back on the sender
   // ------------------------------------------------------------------
   int rsp_hold_left = 0;
   bit rsp_hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_rdy <= 1'b0;
         end else if (!rsp_hold_done && accepted_count >= 300) begin
            rsp_hold_done = 1'b1;
            rsp_hold_left = 400;
            rsp_rdy <= 1'b0;
         end else begin
            rsp_rdy <= calm_stretch || ($urandom_range(0, 99) >= 19);
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: both handshakes sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      bnd_pkg::result_type want;
      req_taken = !reset && req_vld && req_bus.ready;
      if (req_taken) begin
         expected_results.push_back(compute_nesting(CHECK_VIEW, cur_word));
         accepted_count++;
      end
      if (!reset && rsp_bus.valid && rsp_rdy) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual depth %0d inv %0b chg %0b ovf %0b",
                     $time, rsp_bus.nesting_depth, rsp_bus.depth_invalid,
                     rsp_bus.depth_changed, rsp_bus.stack_overflow);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("nesting_depth", want.nesting_depth, rsp_bus.nesting_depth);
            check_field("depth_invalid", want.depth_invalid, rsp_bus.depth_invalid);
            check_field("depth_changed", want.depth_changed, rsp_bus.depth_changed);
            check_field("stack_overflow", want.stack_overflow, rsp_bus.stack_overflow);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int                           n;
      int                           shape;
      logic [bnd_pkg::START_W-1:0]  pos;
      logic [bnd_pkg::START_W:0]    step_pos;
      logic [bnd_pkg::LEN_W-1:0]    len;

      // --- directed words ---
      add_word(32'd0, 32'd0, 1'b0, 1'b0, 6'd0, 1'b1, 1'b0);       // invalid on empty stack
      add_word(32'd0, 32'd0, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0);       // first push, depth 0
      add_word(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0); // prev invalid forces change
      add_word(32'd5, 32'd3, 1'b1, 1'b0, 6'd2, 1'b0, 1'b0);       // nested, unchanged
      add_word(32'd9, 32'd0, 1'b1, 1'b0, 6'd63, 1'b0, 1'b0);      // pops end 8
      add_word(32'd9, 32'd4, 1'b1, 1'b0, 6'd2, 1'b0, 1'b0);       // start equals top end: nest
      add_word(32'd14, 32'd1, 1'b1, 1'b0, 6'd2, 1'b0, 1'b0);      // pops two
      add_word(32'd20, 32'd7, 1'b0, 1'b0, 6'h2A, 1'b1, 1'b1);     // invalid still clears
      add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd63, 1'b0, 1'b0); // 33-bit end
      add_word(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, 6'd1, 1'b0, 1'b1);
      add_word(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 6'd0, 1'b0, 1'b0);
      add_word(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, 6'd0, 1'b0, 1'b1);
      add_word(32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 1'b0, 6'd21, 1'b0, 1'b1);

      // --- random passes ---
      while (pending_words.size() < 1140) begin
         shape = $urandom_range(0, 99);
         if (shape < 12) begin
            // deep pass: strictly nested spans, then one word past all of
            // them; long ones overflow the stack and unwind a full stack
            n   = $urandom_range(20, 72);
            pos = $urandom_range(0, 1_000_000);
            for (int i = 0; i < n; i++)
               add_word(pos + i, 2 * (n - i), 1'b1, 1'($urandom_range(0, 1)), 6'($urandom),
                        $urandom_range(0, 99) < 10, 1'b0);
            add_word(pos + 2 * n + 5, $urandom_range(0, 8), 1'b1, 1'($urandom_range(0, 1)),
                     6'($urandom), 1'b0, 1'b1);
         end else if (shape < 22) begin
            // noise: anything goes, starts out of order too
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
               add_word($urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, 6'($urandom),
                        1'($urandom_range(0, 1)),
                        (i == n - 1) || ($urandom_range(0, 9) == 0));
         end else begin
            // ordinary pass, ascending starts with mixed span lengths
            n = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
               0, 1:    pos = $urandom_range(0, 1000);
               2:       pos = $urandom;
               default: pos = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            endcase
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: len = $urandom_range(0, 8);
                  3, 4:    len = $urandom_range(0, 64);
                  5, 6:    len = $urandom_range(0, 4096);
                  7:       len = 32'hFFFF_FFFF;
                  8:       len = $urandom;
                  default: len = 32'd0;
               endcase
               add_word(pos, len, $urandom_range(0, 99) < 90, 1'($urandom_range(0, 1)),
                        6'($urandom), $urandom_range(0, 99) < 10,
                        (i == n - 1) || ($urandom_range(0, 49) == 0));
               // saturate so the pass stays ascending near the top
               step_pos = {1'b0, pos} + $urandom_range(0, 16);
               pos = step_pos[bnd_pkg::START_W] ? 32'hFFFF_FFFF
                                                : step_pos[bnd_pkg::START_W-1:0];
            end
         end
      end

      // reset once, then release at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // drain: everything sent, everything answered
      while (pending_words.size() != 0 || req_vld || expected_results.size() != 0)
         @(posedge clock);
      // keep running after the drain to watch for strays
      repeat (150) @(posedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
